@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the checker module of the SCCB bus master.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define SBMS_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// A condition that, when seen, must be followed in the next cycle by another.
`define SBMS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/sbms_pkg.sv @@
// Types and constants shared by the SCCB bus master sequencer.
`default_nettype none

package sbms_pkg;

    // Item modes carried on the input channel.
    localparam logic [2:0] MODE_TICK  = 3'd0;
    localparam logic [2:0] MODE_START = 3'd1;
    localparam logic [2:0] MODE_STOP  = 3'd2;
    localparam logic [2:0] MODE_WRITE = 3'd3;
    localparam logic [2:0] MODE_READ  = 3'd4;
    localparam logic [2:0] MODE_NOACK = 3'd5;

    // Kind of the command sequence in progress.
    typedef enum logic [2:0] {
        KIND_IDLE  = 3'd0,
        KIND_START = 3'd1,
        KIND_STOP  = 3'd2,
        KIND_WRITE = 3'd3,
        KIND_READ  = 3'd4,
        KIND_NOACK = 3'd5
    } t_kind;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_TICKS    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_WAIT_TICKS = 1'b1;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [15:0] PHASE_TICKS_RST    = 16'd100;
    localparam logic [15:0] ACK_WAIT_TICKS_RST = 16'd1000;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] data_in;
        logic       sda_in;
    } t_in_item;

    typedef struct packed {
        logic       scl;
        logic       sda_out;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       ack_ok;
        logic       rejected;
    } t_res_item;

endpackage

`default_nettype wire

@@ hw/rtl/sbms_in_if.sv @@
// Input channel of the SCCB bus master: mode, byte to send and sampled data line.
`default_nettype none

interface sbms_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] mode;
    logic [7:0] data_in;
    logic       sda_in;

    modport source (output valid, output mode, output data_in, output sda_in, input ready);
    modport sink   (input valid, input mode, input data_in, input sda_in, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/sbms_out_if.sv @@
// Result channel of the SCCB bus master: line levels and sequence status.
`default_nettype none

interface sbms_out_if;
    logic       valid;
    logic       ready;
    logic       scl;
    logic       sda_out;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_ok;
    logic       rejected;

    modport source (
        output valid, output scl, output sda_out, output sda_drive, output busy_res,
        output done_res, output read_data, output ack_ok, output rejected, input ready
    );
    modport sink (
        input valid, input scl, input sda_out, input sda_drive, input busy_res,
        input done_res, input read_data, input ack_ok, input rejected, output ready
    );
endinterface

`default_nettype wire

@@ hw/rtl/sbms_in_stage.sv @@
// Input register of the SCCB bus master: holds one item until the sequencer takes it.
`default_nettype none

module sbms_in_stage (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire sbms_pkg::t_in_item i_item,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output sbms_pkg::t_in_item     o_item
);

    logic               r_valid;
    sbms_pkg::t_in_item r_item;

    // The register may load whenever it is empty or its item leaves in this cycle.
    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/sbms_core.sv @@
// Sequencer state and the single-pass update that one tick or command makes to it.
`default_nettype none

module sbms_core (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [sbms_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [sbms_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wire logic                                i_valid,
    output logic                                     o_ready,
    input  wire sbms_pkg::t_in_item                  i_item,
    output logic                                     o_valid,
    input  wire logic                                i_ready,
    output sbms_pkg::t_res_item                      o_res
);

    typedef struct packed {
        sbms_pkg::t_kind kind;
        logic [2:0]      step;
        logic [3:0]      bitc;
        logic [15:0]     pcnt;
        logic [7:0]      shift;
        logic            scl;
        logic            sda;
        logic            en;
        logic            ack;
    } t_seq_state;

    typedef struct packed {
        t_seq_state st;
        logic       ok;
    } t_enter;

    logic [15:0] r_phase_ticks;
    logic [15:0] r_ack_wait_ticks;
    t_seq_state  r_st;
    t_seq_state  n_st;
    logic        done;
    logic        rej;
    logic        fire;

    // A zero duration counts as one tick.
    function automatic logic [15:0] f_load(input logic [15:0] t);
        return (t == 16'd0) ? 16'd1 : t;
    endfunction

    // Entry action of the current step; ok is low when the sequence has ended.
    function automatic t_enter f_enter(
        input t_seq_state  s,
        input logic        sda,
        input logic [15:0] pt,
        input logic [15:0] aw
    );
        t_enter     r;
        logic [2:0] bidx;
        logic       long_phase;
        r          = '{st: s, ok: 1'b1};
        bidx       = 3'd7 - s.bitc[2:0];
        long_phase = 1'b0;
        unique case (s.kind)
            sbms_pkg::KIND_START: begin
                unique case (s.step)
                    3'd0:    r.st.sda = 1'b1;
                    3'd1:    r.st.scl = 1'b1;
                    3'd2:    r.st.sda = 1'b0;
                    3'd3:    r.st.scl = 1'b0;
                    default: r.ok = 1'b0;
                endcase
            end
            sbms_pkg::KIND_STOP: begin
                unique case (s.step)
                    3'd0:    r.st.sda = 1'b0;
                    3'd1:    r.st.scl = 1'b1;
                    3'd2:    r.st.sda = 1'b1;
                    default: r.ok = 1'b0;
                endcase
            end
            sbms_pkg::KIND_NOACK: begin
                unique case (s.step)
                    3'd0:    r.st.sda = 1'b1;
                    3'd1:    r.st.scl = 1'b1;
                    3'd2:    r.st.scl = 1'b0;
                    3'd3:    r.st.sda = 1'b0;
                    default: r.ok = 1'b0;
                endcase
            end
            sbms_pkg::KIND_WRITE: begin
                unique case (s.step)
                    3'd0: r.st.sda = s.shift[bidx];
                    3'd1: r.st.scl = 1'b1;
                    3'd2: r.st.scl = 1'b0;
                    3'd3: ;
                    3'd4: r.st.en = 1'b0;
                    3'd5: begin
                        r.st.scl   = 1'b1;
                        long_phase = 1'b1;
                    end
                    3'd6: begin
                        r.st.ack = !sda;
                        r.st.scl = 1'b0;
                    end
                    default: begin
                        r.st.en = 1'b1;
                        r.ok    = 1'b0;
                    end
                endcase
            end
            sbms_pkg::KIND_READ: begin
                unique case (s.step)
                    3'd0: r.st.en = 1'b0;
                    3'd1: ;
                    3'd2: r.st.scl = 1'b1;
                    3'd3: begin
                        r.st.shift = {s.shift[6:0], sda};
                        r.st.scl   = 1'b0;
                    end
                    default: r.ok = 1'b0;
                endcase
            end
            default: r.ok = 1'b0;
        endcase
        if (r.ok) begin
            r.st.pcnt = f_load(long_phase ? aw : pt);
        end
        return r;
    endfunction

    assign fire    = i_valid && i_ready;
    assign o_valid = i_valid;
    assign o_ready = i_ready;

    // Next state for the item at the head of the input register.
    always_comb begin
        t_enter e;
        logic   busy;
        n_st = r_st;
        done = 1'b0;
        rej  = 1'b0;
        e    = '0;
        busy = (r_st.kind != sbms_pkg::KIND_IDLE);
        unique case (i_item.mode)
            sbms_pkg::MODE_TICK: begin
                if (busy) begin
                    if (r_st.pcnt > 16'd1) begin
                        n_st.pcnt = r_st.pcnt - 16'd1;
                    end else begin
                        if (r_st.kind == sbms_pkg::KIND_WRITE && r_st.step == 3'd2) begin
                            n_st.bitc = r_st.bitc + 4'd1;
                            n_st.step = (n_st.bitc < 4'd8) ? 3'd0 : 3'd3;
                        end else if (r_st.kind == sbms_pkg::KIND_READ && r_st.step == 3'd3) begin
                            n_st.bitc = r_st.bitc + 4'd1;
                            n_st.step = (n_st.bitc < 4'd8) ? 3'd1 : 3'd4;
                        end else begin
                            n_st.step = r_st.step + 3'd1;
                        end
                        e    = f_enter(n_st, i_item.sda_in, r_phase_ticks, r_ack_wait_ticks);
                        n_st = e.st;
                        if (!e.ok) begin
                            n_st.kind = sbms_pkg::KIND_IDLE;
                            n_st.step = 3'd0;
                            n_st.bitc = 4'd0;
                            n_st.pcnt = 16'd0;
                            done      = 1'b1;
                        end
                    end
                end
            end
            sbms_pkg::MODE_START, sbms_pkg::MODE_STOP, sbms_pkg::MODE_WRITE,
            sbms_pkg::MODE_READ, sbms_pkg::MODE_NOACK: begin
                if (busy) begin
                    rej = 1'b1;
                end else begin
                    n_st.kind = sbms_pkg::t_kind'(i_item.mode);
                    n_st.step = 3'd0;
                    n_st.bitc = 4'd0;
                    if (i_item.mode == sbms_pkg::MODE_WRITE) begin
                        n_st.shift = i_item.data_in;
                    end else if (i_item.mode == sbms_pkg::MODE_READ) begin
                        n_st.shift = 8'd0;
                    end
                    if (i_item.mode != sbms_pkg::MODE_READ) begin
                        n_st.en = 1'b1;
                    end
                    e    = f_enter(n_st, i_item.sda_in, r_phase_ticks, r_ack_wait_ticks);
                    n_st = e.st;
                    if (!e.ok) begin
                        n_st.kind = sbms_pkg::KIND_IDLE;
                        n_st.step = 3'd0;
                        n_st.bitc = 4'd0;
                        n_st.pcnt = 16'd0;
                    end
                end
            end
            default: ;
        endcase
    end

    // Result fields show the state as it stands after the item.
    always_comb begin
        o_res.scl       = n_st.scl;
        o_res.sda_out   = n_st.sda;
        o_res.sda_drive = n_st.en;
        o_res.busy_res  = (n_st.kind != sbms_pkg::KIND_IDLE);
        o_res.done_res  = done;
        o_res.read_data = n_st.shift;
        o_res.ack_ok    = n_st.ack;
        o_res.rejected  = rej;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.kind  <= sbms_pkg::KIND_IDLE;
            r_st.step  <= 3'd0;
            r_st.bitc  <= 4'd0;
            r_st.pcnt  <= 16'd0;
            r_st.shift <= 8'd0;
            r_st.scl   <= 1'b1;
            r_st.sda   <= 1'b1;
            r_st.en    <= 1'b1;
            r_st.ack   <= 1'b0;
        end else if (fire) begin
            r_st <= n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ticks    <= sbms_pkg::PHASE_TICKS_RST;
            r_ack_wait_ticks <= sbms_pkg::ACK_WAIT_TICKS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                sbms_pkg::CFG_PHASE_TICKS:    r_phase_ticks    <= i_cfg_data;
                sbms_pkg::CFG_ACK_WAIT_TICKS: r_ack_wait_ticks <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/sbms_out_stage.sv @@
// Result register of the SCCB bus master: holds one result until the sink takes it.
`default_nettype none

module sbms_out_stage (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire sbms_pkg::t_res_item i_res,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output sbms_pkg::t_res_item      o_res
);

    logic                r_valid;
    sbms_pkg::t_res_item r_res;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_res <= i_res;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/sccb_bus_master_sequencer.sv @@
// SCCB bus master sequencer: every transfer on the input channel is a time tick, a command
// (start, stop, write byte, read byte, no-ack) or an ignored spare mode, and each produces
// exactly one result giving the clock level, data level, data drive enable and sequence
// status after that item. One item is taken every clock cycle when the result side keeps
// up; a result passes through the input register and then the result register, with the
// whole state update done between them. Bus timing is counted in ticks, not clock cycles:
// phase_ticks per ordinary phase and ack_wait_ticks for the acknowledge high phase of a
// write. Commands that arrive during a sequence are reported as rejected.
// Configuration writes are to be made only while no items are in flight.
`default_nettype none

module sccb_bus_master_sequencer (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [sbms_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [sbms_pkg::CFG_DATA_W-1:0] i_cfg_data,
    sbms_in_if.sink                              i_in,
    sbms_out_if.source                           o_out
);

    sbms_pkg::t_in_item  in_item;
    sbms_pkg::t_in_item  head_item;
    sbms_pkg::t_res_item core_res;
    sbms_pkg::t_res_item out_res;
    logic                head_valid;
    logic                head_ready;
    logic                res_valid;
    logic                res_ready;

    assign in_item.mode    = i_in.mode;
    assign in_item.data_in = i_in.data_in;
    assign in_item.sda_in  = i_in.sda_in;

    sbms_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (i_in.ready),
        .i_item  (in_item),
        .o_valid (head_valid),
        .i_ready (head_ready),
        .o_item  (head_item)
    );

    sbms_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (head_valid),
        .o_ready    (head_ready),
        .i_item     (head_item),
        .o_valid    (res_valid),
        .i_ready    (res_ready),
        .o_res      (core_res)
    );

    sbms_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (res_valid),
        .o_ready (res_ready),
        .i_res   (core_res),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_res   (out_res)
    );

    assign o_out.scl       = out_res.scl;
    assign o_out.sda_out   = out_res.sda_out;
    assign o_out.sda_drive = out_res.sda_drive;
    assign o_out.busy_res  = out_res.busy_res;
    assign o_out.done_res  = out_res.done_res;
    assign o_out.read_data = out_res.read_data;
    assign o_out.ack_ok    = out_res.ack_ok;
    assign o_out.rejected  = out_res.rejected;

endmodule

`default_nettype wire

@@ hw/rtl/sbms_checker.sv @@
// Port-level checks of the SCCB bus master sequencer and their binding to the top level.
`default_nettype none
`include "assert_macros.svh"

module sbms_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic       i_busy_res,
    input wire logic       i_done_res,
    input wire logic       i_rejected,
    input wire logic       i_scl,
    input wire logic [7:0] i_read_data
);

    logic       stalled;
    logic [9:0] held;

    // A result that waits keeps its valid flag, its clock level and its read data.
    assign stalled = i_out_valid && !i_out_ready;
    assign held    = {i_out_valid, i_scl, i_read_data};

    // A finished sequence leaves the block idle.
    `SBMS_ASSERT(a_done_idle, !(i_out_valid && i_done_res && i_busy_res), "done while busy")

    // A command is only rejected while a sequence is running, which it leaves running.
    `SBMS_ASSERT(a_rej_busy, !(i_out_valid && i_rejected && !i_busy_res), "reject when idle")

    // Rejection and completion never come from the same item.
    `SBMS_ASSERT(a_rej_done, !(i_out_valid && i_rejected && i_done_res), "reject and done")

    // A stalled result keeps its valid flag, clock level and read data unchanged.
    `SBMS_ASSERT_NEXT(a_out_hold, stalled, $stable(held), "result changed while stalled")

endmodule

bind sccb_bus_master_sequencer sbms_checker u_sbms_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_busy_res  (o_out.busy_res),
    .i_done_res  (o_out.done_res),
    .i_rejected  (o_out.rejected),
    .i_scl       (o_out.scl),
    .i_read_data (o_out.read_data)
);

`default_nettype wire

@@ tb/sv/sccb_bus_master_sequencer_tb.sv @@
// Self-checking testbench for the SCCB bus master sequencer, with a line-level scoreboard.
`default_nettype none

module sccb_bus_master_sequencer_tb;

    // Modes that the block must ignore without reporting a rejection.
    localparam logic [2:0] MODE_SPARE_LO = 3'd6;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;

    localparam int unsigned SETTLE_CYCLES = 6;

    // Predicts the bus levels and status after every transfer and checks them in order.
    class bus_level_scoreboard;
        bit [15:0]           phase_ticks;
        bit [15:0]           ack_wait_ticks;
        sbms_pkg::t_kind     kind;
        bit [2:0]            step;
        bit [3:0]            bit_cnt;
        bit [15:0]           ticks_left;
        bit [7:0]            shift_reg;
        bit                  scl_q;
        bit                  sda_q;
        bit                  drive_q;
        bit                  ack_q;
        sbms_pkg::t_res_item expected_levels[$];
        int                  errors;

        function new();
            phase_ticks    = sbms_pkg::PHASE_TICKS_RST;
            ack_wait_ticks = sbms_pkg::ACK_WAIT_TICKS_RST;
            shift_reg      = '0;
            scl_q          = 1'b1;
            sda_q          = 1'b1;
            drive_q        = 1'b1;
            ack_q          = 1'b0;
            errors         = 0;
            go_idle();
        endfunction

        function void set_reg(logic [sbms_pkg::CFG_IDX_W-1:0] idx, bit [15:0] value);
            if (idx == sbms_pkg::CFG_PHASE_TICKS) begin
                phase_ticks = value;
            end else begin
                ack_wait_ticks = value;
            end
        endfunction

        function void go_idle();
            kind       = sbms_pkg::KIND_IDLE;
            step       = '0;
            bit_cnt    = '0;
            ticks_left = '0;
        endfunction

        function bit busy();
            return kind != sbms_pkg::KIND_IDLE;
        endfunction

        function int pending();
            return expected_levels.size();
        endfunction

        // A zero duration counts as a single tick.
        function void load_time(bit [15:0] t);
            ticks_left = (t == 16'd0) ? 16'd1 : t;
        endfunction

        // Sets the levels on entry to the current step; returns 0 once the sequence is over.
        function bit enter_phase(bit sda);
            bit [2:0] pos;
            case (kind)
                sbms_pkg::KIND_START: begin
                    case (step)
                        3'd0: sda_q = 1'b1;
                        3'd1: scl_q = 1'b1;
                        3'd2: sda_q = 1'b0;
                        3'd3: scl_q = 1'b0;
                        default: return 1'b0;
                    endcase
                end
                sbms_pkg::KIND_STOP: begin
                    case (step)
                        3'd0: sda_q = 1'b0;
                        3'd1: scl_q = 1'b1;
                        3'd2: sda_q = 1'b1;
                        default: return 1'b0;
                    endcase
                end
                sbms_pkg::KIND_NOACK: begin
                    case (step)
                        3'd0: sda_q = 1'b1;
                        3'd1: scl_q = 1'b1;
                        3'd2: scl_q = 1'b0;
                        3'd3: sda_q = 1'b0;
                        default: return 1'b0;
                    endcase
                end
                sbms_pkg::KIND_WRITE: begin
                    case (step)
                        3'd0: begin
                            pos   = 3'd7 - bit_cnt[2:0];
                            sda_q = shift_reg[pos];
                        end
                        3'd1: scl_q = 1'b1;
                        3'd2: scl_q = 1'b0;
                        3'd3: ;
                        3'd4: drive_q = 1'b0;
                        3'd5: begin
                            scl_q = 1'b1;
                            load_time(ack_wait_ticks);
                            return 1'b1;
                        end
                        3'd6: begin
                            ack_q = !sda;
                            scl_q = 1'b0;
                        end
                        default: begin
                            drive_q = 1'b1;
                            return 1'b0;
                        end
                    endcase
                end
                sbms_pkg::KIND_READ: begin
                    case (step)
                        3'd0: drive_q = 1'b0;
                        3'd1: ;
                        3'd2: scl_q = 1'b1;
                        3'd3: begin
                            shift_reg = {shift_reg[6:0], sda};
                            scl_q     = 1'b0;
                        end
                        default: return 1'b0;
                    endcase
                end
                default: return 1'b0;
            endcase
            load_time(phase_ticks);
            return 1'b1;
        endfunction

        function void note_item(sbms_pkg::t_in_item it);
            sbms_pkg::t_res_item lv;
            bit                  done;
            bit                  rej;
            done = 1'b0;
            rej  = 1'b0;
            if (it.mode == sbms_pkg::MODE_TICK) begin
                if (busy()) begin
                    if (ticks_left > 16'd1) begin
                        ticks_left--;
                    end else begin
                        if (kind == sbms_pkg::KIND_WRITE && step == 3'd2) begin
                            bit_cnt++;
                            step = (bit_cnt < 4'd8) ? 3'd0 : 3'd3;
                        end else if (kind == sbms_pkg::KIND_READ && step == 3'd3) begin
                            bit_cnt++;
                            step = (bit_cnt < 4'd8) ? 3'd1 : 3'd4;
                        end else begin
                            step++;
                        end
                        if (!enter_phase(it.sda_in)) begin
                            go_idle();
                            done = 1'b1;
                        end
                    end
                end
            end else if (it.mode <= sbms_pkg::MODE_NOACK) begin
                if (busy()) begin
                    rej = 1'b1;
                end else begin
                    kind    = sbms_pkg::t_kind'(it.mode);
                    step    = '0;
                    bit_cnt = '0;
                    if (it.mode == sbms_pkg::MODE_WRITE) begin
                        shift_reg = it.data_in;
                    end else if (it.mode == sbms_pkg::MODE_READ) begin
                        shift_reg = '0;
                    end
                    if (it.mode != sbms_pkg::MODE_READ) begin
                        drive_q = 1'b1;
                    end
                    if (!enter_phase(it.sda_in)) begin
                        go_idle();
                    end
                end
            end
            lv.scl       = scl_q;
            lv.sda_out   = sda_q;
            lv.sda_drive = drive_q;
            lv.busy_res  = busy();
            lv.done_res  = done;
            lv.read_data = shift_reg;
            lv.ack_ok    = ack_q;
            lv.rejected  = rej;
            expected_levels.push_back(lv);
        endfunction

        function void cmp_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, got %0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_levels(sbms_pkg::t_res_item got);
            sbms_pkg::t_res_item want;
            if (expected_levels.size() == 0) begin
                $error("result transfer with no expectation waiting");
                errors++;
                return;
            end
            want = expected_levels.pop_front();
            cmp_field("scl", 8'(want.scl), 8'(got.scl));
            cmp_field("sda_out", 8'(want.sda_out), 8'(got.sda_out));
            cmp_field("sda_drive", 8'(want.sda_drive), 8'(got.sda_drive));
            cmp_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
            cmp_field("done_res", 8'(want.done_res), 8'(got.done_res));
            cmp_field("read_data", want.read_data, got.read_data);
            cmp_field("ack_ok", 8'(want.ack_ok), 8'(got.ack_ok));
            cmp_field("rejected", 8'(want.rejected), 8'(got.rejected));
        endfunction
    endclass

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [sbms_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [sbms_pkg::CFG_DATA_W-1:0] i_cfg_data;

    sbms_in_if  in_ch ();
    sbms_out_if out_ch ();

    bus_level_scoreboard sb = new();
    int burst_left = 0;

    sccb_bus_master_sequencer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Sends one item, opening a new burst after a random gap when the current one runs out.
    task automatic send_item(input sbms_pkg::t_in_item it);
        int gap;
        if (burst_left <= 0) begin
            gap        = $urandom_range(0, 6);
            burst_left = $urandom_range(1, 48);
            if (gap != 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        in_ch.valid   <= 1'b1;
        in_ch.mode    <= it.mode;
        in_ch.data_in <= it.data_in;
        in_ch.sda_in  <= it.sda_in;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sb.note_item(it);
        burst_left--;
    endtask

    // sda_pol: 0 or 1 holds the data line at that level, anything else drives it at random.
    task automatic send_mode(input logic [2:0] mode, input int sda_pol);
        sbms_pkg::t_in_item it;
        it.mode    = mode;
        it.data_in = 8'($urandom_range(0, 255));
        it.sda_in  = (sda_pol == 0) ? 1'b0 : (sda_pol == 1) ? 1'b1 : 1'($urandom_range(0, 1));
        send_item(it);
    endtask

    task automatic run_to_idle(input int sda_pol);
        while (sb.busy()) send_mode(sbms_pkg::MODE_TICK, sda_pol);
    endtask

    task automatic run_command(input logic [2:0] mode, input logic [7:0] data, input int sda_pol);
        sbms_pkg::t_in_item it;
        it.mode    = mode;
        it.data_in = data;
        it.sda_in  = 1'($urandom_range(0, 1));
        send_item(it);
        run_to_idle(sda_pol);
    endtask

    // Waits until every expected result has arrived and the pipeline has settled.
    task automatic drain();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(
        input logic [sbms_pkg::CFG_IDX_W-1:0] idx,
        input logic [15:0]                    value
    );
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_reg(idx, value);
    endtask

    task automatic set_timing(input logic [15:0] phase, input logic [15:0] ack_wait);
        write_reg(sbms_pkg::CFG_PHASE_TICKS, phase);
        write_reg(sbms_pkg::CFG_ACK_WAIT_TICKS, ack_wait);
    endtask

    // Mostly well-formed command sequences with random content, with rejected commands and
    // ignored items mixed in. Ignored items do not count towards n.
    task automatic run_random(input int n);
        int         sent;
        int         pick;
        int         roll;
        logic [2:0] mode;
        sent = 0;
        while (sent < n) begin
            pick = $urandom_range(0, 99);
            if (!sb.busy()) begin
                if (pick < 8) begin
                    mode = sbms_pkg::MODE_TICK;
                end else if (pick < 12) begin
                    mode = $urandom_range(0, 1) ? MODE_SPARE_HI : MODE_SPARE_LO;
                end else begin
                    roll = $urandom_range(0, 99);
                    if (roll < 20) mode = sbms_pkg::MODE_START;
                    else if (roll < 35) mode = sbms_pkg::MODE_STOP;
                    else if (roll < 65) mode = sbms_pkg::MODE_WRITE;
                    else if (roll < 88) mode = sbms_pkg::MODE_READ;
                    else mode = sbms_pkg::MODE_NOACK;
                    sent++;
                end
            end else begin
                if (pick < 92) begin
                    mode = sbms_pkg::MODE_TICK;
                    sent++;
                end else if (pick < 97) begin
                    mode = 3'($urandom_range(sbms_pkg::MODE_START, sbms_pkg::MODE_NOACK));
                    sent++;
                end else begin
                    mode = $urandom_range(0, 1) ? MODE_SPARE_HI : MODE_SPARE_LO;
                end
            end
            send_mode(mode, 2);
        end
    endtask

    // Result side: alternates stretches of full speed, random stalls, a fixed pattern and
    // short blackouts.
    initial begin
        sbms_pkg::t_res_item got;
        int                  pattern;
        int                  stretch;
        int                  cnt;
        out_ch.ready <= 1'b0;
        pattern = 0;
        stretch = 0;
        cnt     = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready) begin
                got.scl       = out_ch.scl;
                got.sda_out   = out_ch.sda_out;
                got.sda_drive = out_ch.sda_drive;
                got.busy_res  = out_ch.busy_res;
                got.done_res  = out_ch.done_res;
                got.read_data = out_ch.read_data;
                got.ack_ok    = out_ch.ack_ok;
                got.rejected  = out_ch.rejected;
                sb.check_levels(got);
            end
            if (stretch <= 0) begin
                pattern = $urandom_range(0, 3);
                stretch = (pattern == 3) ? $urandom_range(1, 8) : $urandom_range(20, 200);
            end
            stretch--;
            cnt++;
            case (pattern)
                0: out_ch.ready <= 1'b1;
                1: out_ch.ready <= ($urandom_range(0, 9) < 7);
                2: out_ch.ready <= (cnt % 4 != 3);
                default: out_ch.ready <= 1'b0;
            endcase
        end
    end

    initial begin
        int m;
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_idx      <= '0;
        i_cfg_data     <= '0;
        in_ch.valid    <= 1'b0;
        in_ch.mode     <= sbms_pkg::MODE_TICK;
        in_ch.data_in  <= '0;
        in_ch.sda_in   <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset timing: ignored items while idle, then a start with every command rejected.
        send_mode(sbms_pkg::MODE_TICK, 2);
        send_mode(MODE_SPARE_LO, 2);
        send_mode(MODE_SPARE_HI, 2);
        send_mode(sbms_pkg::MODE_START, 2);
        for (m = sbms_pkg::MODE_START; m <= sbms_pkg::MODE_NOACK; m++) send_mode(3'(m), 2);
        run_to_idle(2);

        set_timing(16'd1, 16'd1);
        run_command(sbms_pkg::MODE_WRITE, 8'h00, 0);
        run_command(sbms_pkg::MODE_WRITE, 8'hFF, 1);
        run_command(sbms_pkg::MODE_WRITE, 8'hA5, 2);
        run_command(sbms_pkg::MODE_READ, 8'h00, 1);
        run_command(sbms_pkg::MODE_READ, 8'hFF, 0);
        run_command(sbms_pkg::MODE_READ, 8'h5A, 2);
        run_command(sbms_pkg::MODE_NOACK, 8'h00, 2);
        run_command(sbms_pkg::MODE_STOP, 8'hFF, 2);
        run_command(sbms_pkg::MODE_START, 8'h00, 2);

        // A zero duration behaves as a single tick.
        set_timing(16'd0, 16'd0);
        run_random(150);
        set_timing(16'd2, 16'd3);
        run_random(150);
        set_timing(16'd1, 16'd7);
        run_random(150);
        set_timing(16'd3, 16'd1);
        run_random(150);

        // A long acknowledge wait on a single write.
        set_timing(16'd1, 16'd160);
        run_command(sbms_pkg::MODE_WRITE, 8'($urandom_range(0, 255)), 2);

        // A long phase: only the first phase of a start uses it, the rest run short.
        write_reg(sbms_pkg::CFG_PHASE_TICKS, 16'd120);
        send_mode(sbms_pkg::MODE_START, 2);
        repeat (20) send_mode(sbms_pkg::MODE_TICK, 2);
        write_reg(sbms_pkg::CFG_PHASE_TICKS, 16'd1);
        run_to_idle(2);

        set_timing(16'd1, 16'd2);
        run_random(100);

        drain();
        repeat (16) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("sccb_bus_master_sequencer_tb: PASS");
        end else begin
            $display("sccb_bus_master_sequencer_tb: FAIL");
        end
        $finish;
    end

    initial begin
        #100_000_000;
        $display("sccb_bus_master_sequencer_tb: FAIL");
        $finish;
    end

endmodule

`default_nettype wire

@@ files.f @@
+incdir+hw/rtl
hw/rtl/sbms_pkg.sv
hw/rtl/sbms_in_if.sv
hw/rtl/sbms_out_if.sv
hw/rtl/sbms_in_stage.sv
hw/rtl/sbms_core.sv
hw/rtl/sbms_out_stage.sv
hw/rtl/sccb_bus_master_sequencer.sv
hw/rtl/sbms_checker.sv
tb/sv/sccb_bus_master_sequencer_tb.sv
